FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on a clock that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/lru_pkg.sv
// Types and constants of the LRU page replacement block.
package lru_pkg;

   // Built number of page frames and derived widths.
   localparam int MAX_FRAMES = 16;
   localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
   localparam int PAGE_W     = 16;
   localparam int FAULT_W    = 16;
   localparam int CFG_W      = 5;
   localparam int LIM_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);
   localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

   // One reference beat.
   typedef struct packed {
      logic [PAGE_W-1:0] page_number;
      logic              end_of_string;
   } lru_req_type;

   // One result beat.
   typedef struct packed {
      logic               hit;
      logic               evicted_valid;
      logic [PAGE_W-1:0]  evicted_page;
      logic [FAULT_W-1:0] fault_total;
   } lru_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
   } lru_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } lru_state_type;

endpackage

FILE: design/lru_ctrl.sv
// Controller of the LRU block: request and result handshakes.
module lru_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lru_pkg::lru_cmd_type cmd
);
   import lru_pkg::*;

   lru_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   // The result register can take a new beat when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and commands.
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EXEC: begin
            cmd.exec  = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Result valid flag follows the execute step and the downstream take.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/lru_dpath.sv
// Datapath of the LRU block: recency stack cells, counters and result register.
module lru_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  lru_pkg::lru_cmd_type     cmd,
   input  lru_pkg::lru_req_type     req_payload,
   input  logic                     csr_valid,
   input  logic [lru_pkg::CFG_W-1:0] csr_data,
   output lru_pkg::lru_rsp_type     rsp_payload
);
   import lru_pkg::*;

   logic [PAGE_W-1:0]  stack_ff [MAX_FRAMES];
   logic [PAGE_W-1:0]  stack_in [MAX_FRAMES];
   logic [PAGE_W-1:0]  stack_up [MAX_FRAMES];
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [FAULT_W-1:0] fault_ff, fault_in;
   logic [CFG_W-1:0]   frames_ff;
   lru_req_type        req_ff;
   lru_rsp_type        rsp_ff, rsp_in;

   logic [MAX_FRAMES-1:0] match;
   logic [MAX_FRAMES-1:0] at_or_above;
   logic                  found;
   logic [LIM_W-1:0]      lim;
   logic                  has_room;
   logic [CNT_W-1:0]      top_idx;
   logic [FAULT_W-1:0]    fault_next;

   // Frame limit: zero acts as one, values above the built size are clamped.
   always_comb begin
      if (frames_ff == '0) lim = LIM_W'(1);
      else if (LIM_W'(frames_ff) > LIM_W'(MAX_FRAMES)) lim = LIM_W'(MAX_FRAMES);
      else lim = LIM_W'(frames_ff);
   end

   assign has_room = LIM_W'(used_ff) < lim;
   assign top_idx  = used_ff - CNT_W'(1);

   // Every occupied cell compares against the reference at once.
   always_comb begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
         match[k] = (CNT_W'(k) < used_ff) && (stack_ff[k] == req_ff.page_number);
      end
   end

   assign found = |match;

   // A cell sits at or above the hit position when any match lies at or below it.
   always_comb begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
         at_or_above[k] = |(match & ((MAX_FRAMES'(1) << (k + 1)) - MAX_FRAMES'(1)));
      end
   end

   // Value each cell takes when the stack shifts down by one.
   always_comb begin
      for (int k = 0; k < MAX_FRAMES - 1; k++) begin
         stack_up[k] = stack_ff[k + 1];
      end
      stack_up[MAX_FRAMES-1] = stack_ff[MAX_FRAMES-1];
   end

   // Next stack contents for hit, append and evict.
   always_comb begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
         stack_in[k] = stack_ff[k];
         if (found) begin
            if (CNT_W'(k) == top_idx) stack_in[k] = req_ff.page_number;
            else if (at_or_above[k] && (CNT_W'(k) < top_idx)) stack_in[k] = stack_up[k];
         end else if (has_room) begin
            if (CNT_W'(k) == used_ff) stack_in[k] = req_ff.page_number;
         end else begin
            if (CNT_W'(k) == top_idx) stack_in[k] = req_ff.page_number;
            else if (CNT_W'(k) < top_idx) stack_in[k] = stack_up[k];
         end
      end
   end

   // Saturating fault count and occupancy.
   assign fault_next = (!found && (fault_ff != FAULT_MAX)) ? fault_ff + FAULT_W'(1) : fault_ff;

   always_comb begin
      used_in  = used_ff;
      fault_in = fault_ff;
      if (cmd.exec) begin
         if (req_ff.end_of_string) begin
            used_in  = '0;
            fault_in = '0;
         end else begin
            fault_in = fault_next;
            if (!found && has_room) used_in = used_ff + CNT_W'(1);
         end
      end
   end

   // Result beat.
   always_comb begin
      rsp_in.hit           = found;
      rsp_in.evicted_valid = !found && !has_room;
      rsp_in.evicted_page  = (!found && !has_room) ? stack_ff[0] : '0;
      rsp_in.fault_total   = fault_next;
   end

   // Control state and the frame register.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         fault_ff  <= '0;
         frames_ff <= CFG_RESET;
      end else begin
         used_ff  <= used_in;
         fault_ff <= fault_in;
         if (csr_valid) frames_ff <= csr_data;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_payload;
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
         for (int k = 0; k < MAX_FRAMES; k++) begin
            stack_ff[k] <= stack_in[k];
         end
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

FILE: design/lru_page_replacement.sv
// Top level of the LRU page replacement block.
// A reference beat is loaded into the request register when it is taken; its
// result and rsp_valid are registered in the execute step, which waits until
// the result register is free. No new reference is taken until that step is
// done; the recency cells compare and shift in the execute step.
// Reset empties the stack, clears the fault count and sets the frames to 16.
module lru_page_replacement (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  lru_pkg::lru_req_type      req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output lru_pkg::lru_rsp_type      rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [lru_pkg::CFG_W-1:0] csr_data
);
   import lru_pkg::*;

   lru_cmd_type cmd;

   // The frame register takes a write in any cycle.
   assign csr_ready = 1'b1;

   lru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   lru_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: design/lru_chk.sv
// Port checker for the LRU block and its bind to the top level.
`include "assert_macros.svh"

module lru_chk (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input lru_pkg::lru_req_type      req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input lru_pkg::lru_rsp_type      rsp_payload,
   input logic                      csr_valid,
   input logic                      csr_ready,
   input logic [lru_pkg::CFG_W-1:0] csr_data
);
   import lru_pkg::*;

   // A stalled result beat holds.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "result beat changed while stalled")

   // After a reference is taken the block is busy in the next cycle.
   `ASSERT_CLK_RST(a_busy, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while busy")

   // A hit never evicts, and a result with no eviction reports page zero.
   `ASSERT_CLK_RST(a_evict, clock, reset, rsp_valid |-> !(rsp_payload.hit && rsp_payload.evicted_valid) && (rsp_payload.evicted_valid || rsp_payload.evicted_page == '0), "eviction fields inconsistent")

   // Reset leaves no result pending.
   `ASSERT_CLK(a_reset, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind lru_page_replacement lru_chk u_chk (.*);
